// ----- hw/rtl/imd_pkg.sv -----
// imd_pkg: shared widths and constants for the interval min/max decimator.
// No dependencies; imported by interval_minmax_decimator_core.
`default_nettype none

package imd_pkg;

    // Timestamp width in microseconds
    localparam int unsigned TIME_WIDTH  = 32;
    // Bar counter and bars-per-output register width
    localparam int unsigned COUNT_WIDTH = 16;

    // Reset value of the bars-per-output register (pass-through)
    localparam logic [COUNT_WIDTH-1:0] BARS_RESET = COUNT_WIDTH'(1);
    // Saturation value of the bar counter
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};

endpackage : imd_pkg

`default_nettype wire

// ----- hw/rtl/interval_minmax_decimator_core.sv -----
// interval_minmax_decimator_core: min/max peak-detect decimation of waveform bars.
// Depends on imd_pkg for timestamp and counter widths.
//
// Usage:
//   Input channel s_*: one bar per word (two timestamps, two signed samples,
//   end-of-stream mark), valid/ready handshake. Result channel m_*: one word
//   per closed block (mid time, peak high, peak low, final flag).
//   cfg_wr_en/cfg_wr_data write bars_per_output (0 or 1 = pass-through); write
//   only while the block is idle.
// Order: a bar accepted into the input register is evaluated there, and a result
//   it closes is presented from the result register once the bar advances.
// Throughput: one bar per cycle while m_ready stays high; the input register and
//   the result register form a two-stage pipeline, with the input register
//   advancing whenever the result register is empty or being taken.
// Reset (aresetn low, synchronous): both stages empty, the accumulator is
//   cleared and bars_per_output returns to 1.
// Receiver stall: the result word holds; one more bar waits in the input
//   register, after which s_ready drops until m_ready returns.
`default_nettype none

module interval_minmax_decimator_core
    import imd_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // configuration
    input  wire                           cfg_wr_en,
    input  wire  [COUNT_WIDTH-1:0]        cfg_wr_data,
    // input bars
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [TIME_WIDTH-1:0]         s_time_first,
    input  wire  [TIME_WIDTH-1:0]         s_time_second,
    input  wire  signed [SAMPLE_WIDTH-1:0] s_sample_a,
    input  wire  signed [SAMPLE_WIDTH-1:0] s_sample_b,
    input  wire                           s_end_of_stream,
    // results
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [TIME_WIDTH-1:0]         m_mid_time,
    output logic signed [SAMPLE_WIDTH-1:0] m_peak_high,
    output logic signed [SAMPLE_WIDTH-1:0] m_peak_low,
    output logic                          m_final_flag
);

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // configuration register
    logic [COUNT_WIDTH-1:0] bars_per_output_reg;

    // input register stage
    logic                           in_valid_reg;
    logic [TIME_WIDTH-1:0]          time_first_reg;
    logic [TIME_WIDTH-1:0]          time_second_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_a_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_b_reg;
    logic                           eos_reg;

    // accumulator
    logic [COUNT_WIDTH-1:0]         bar_count_reg, bar_count_next;
    logic signed [SAMPLE_WIDTH-1:0] running_high_reg, running_high_next;
    logic signed [SAMPLE_WIDTH-1:0] running_low_reg, running_low_next;
    logic [TIME_WIDTH-1:0]          start_time_reg, start_time_next;

    // result register
    logic                           out_valid_reg;
    logic [TIME_WIDTH-1:0]          mid_time_reg, mid_time_next;
    logic signed [SAMPLE_WIDTH-1:0] peak_high_reg, peak_high_next;
    logic signed [SAMPLE_WIDTH-1:0] peak_low_reg, peak_low_next;
    logic                           final_reg;

    logic                           advance;
    logic                           pass_mode;
    logic                           close_block;
    logic                           emit;
    logic [TIME_WIDTH:0]            time_sum;
    logic signed [SAMPLE_WIDTH-1:0] high_ab, low_ab;

    // handshake: input stage moves when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // per-bar evaluation against the accumulator
    always_comb begin
        pass_mode = (bars_per_output_reg <= COUNT_WIDTH'(1));
        high_ab   = (sample_a_reg > sample_b_reg) ? sample_a_reg : sample_b_reg;
        low_ab    = (sample_a_reg < sample_b_reg) ? sample_a_reg : sample_b_reg;

        start_time_next   = (bar_count_reg == '0) ? time_first_reg : start_time_reg;
        running_high_next = (high_ab > running_high_reg) ? high_ab : running_high_reg;
        running_low_next  = (low_ab < running_low_reg) ? low_ab : running_low_reg;
        bar_count_next    = (bar_count_reg == COUNT_MAX) ? bar_count_reg
                                                         : bar_count_reg + COUNT_WIDTH'(1);

        close_block = (bar_count_next >= bars_per_output_reg) || eos_reg;
        emit        = pass_mode || close_block;

        // 33-bit sum so the midpoint never wraps
        time_sum = {1'b0, start_time_next} + {1'b0, time_second_reg};

        if (pass_mode) begin
            mid_time_next  = time_first_reg;
            peak_high_next = sample_a_reg;
            peak_low_next  = sample_b_reg;
        end else begin
            mid_time_next  = time_sum[TIME_WIDTH:1];
            peak_high_next = running_high_next;
            peak_low_next  = running_low_next;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bars_per_output_reg <= BARS_RESET;
        end else if (cfg_wr_en) begin
            bars_per_output_reg <= cfg_wr_data;
        end
    end

    // input register stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            time_first_reg  <= s_time_first;
            time_second_reg <= s_time_second;
            sample_a_reg    <= s_sample_a;
            sample_b_reg    <= s_sample_b;
            eos_reg         <= s_end_of_stream;
        end
    end

    // accumulator: cleared when a block closes or in pass-through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_count_reg    <= '0;
            running_high_reg <= SAMPLE_MIN;
            running_low_reg  <= SAMPLE_MAX;
            start_time_reg   <= '0;
        end else if (advance) begin
            if (emit) begin
                bar_count_reg    <= '0;
                running_high_reg <= SAMPLE_MIN;
                running_low_reg  <= SAMPLE_MAX;
                start_time_reg   <= '0;
            end else begin
                bar_count_reg    <= bar_count_next;
                running_high_reg <= running_high_next;
                running_low_reg  <= running_low_next;
                start_time_reg   <= start_time_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            mid_time_reg  <= mid_time_next;
            peak_high_reg <= peak_high_next;
            peak_low_reg  <= peak_low_next;
            final_reg     <= eos_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_mid_time   = mid_time_reg;
    assign m_peak_high  = peak_high_reg;
    assign m_peak_low   = peak_low_reg;
    assign m_final_flag = final_reg;

    // checks
    a_pass_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && pass_mode) |=> (bar_count_reg == '0))
        else $error("pass-through bar left the accumulator open");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> out_valid_reg)
        else $error("closed block produced no result word");

    a_peak_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (bar_count_reg != '0) |-> (running_high_reg >= running_low_reg))
        else $error("running high below running low in an open block");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(bar_count_reg))
        else $error("accumulator moved while the result stage was stalled");

endmodule : interval_minmax_decimator_core

`default_nettype wire

// ----- sim/interval_minmax_decimator_core_tb.sv -----
// interval_minmax_decimator_core_tb: self-checking bench for the min/max bar decimator.
// Depends on imd_pkg and interval_minmax_decimator_core; a directed table runs first,
// then random phases, checked against an in-bench peak predictor or hand-written results.
module interval_minmax_decimator_core_tb;
    import imd_pkg::*;

    localparam int unsigned SW            = 16;
    localparam int unsigned RANDOM_BARS   = 1900;
    localparam int unsigned STEADY_FROM   = 700;
    localparam int unsigned STEADY_TO     = 1000;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned DIRECTED_ROWS = 20;
    localparam int unsigned IDLE_PCT      = 36;

    localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic [TIME_WIDTH-1:0] t_first;
        logic [TIME_WIDTH-1:0] t_second;
        logic [SW-1:0]         a;
        logic [SW-1:0]         b;
        logic                  eos;
    } bar_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] mid;
        logic [SW-1:0]         high;
        logic [SW-1:0]         low;
        logic                  fin;
    } peak_t;

    // one line of the directed table: optional register write, the bar, an optional
    // hand-written result
    typedef struct packed {
        logic                   set_cfg;
        logic [COUNT_WIDTH-1:0] cfg;
        bar_t                   bar;
        logic                   typed;
        peak_t                  want;
    } row_t;

    localparam peak_t NO_WANT = '0;

    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   cfg_wr_en       = 1'b0;
    logic [COUNT_WIDTH-1:0] cfg_wr_data     = '0;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic [TIME_WIDTH-1:0]  s_time_first    = '0;
    logic [TIME_WIDTH-1:0]  s_time_second   = '0;
    logic [SW-1:0]          s_sample_a      = '0;
    logic [SW-1:0]          s_sample_b      = '0;
    logic                   s_end_of_stream = 1'b0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic [TIME_WIDTH-1:0]  m_mid_time;
    logic [SW-1:0]          m_peak_high;
    logic [SW-1:0]          m_peak_low;
    logic                   m_final_flag;

    // predictor state
    logic [COUNT_WIDTH-1:0] bars_cfg;
    logic [COUNT_WIDTH-1:0] acc_count;
    logic signed [SW-1:0]   acc_high;
    logic signed [SW-1:0]   acc_low;
    logic [TIME_WIDTH-1:0]  acc_start;

    peak_t       expected_peaks[$];
    int unsigned fault_count = 0;
    int unsigned idle_cycles = 0;
    bit          steady      = 1'b0;
    row_t        plan [DIRECTED_ROWS];

    interval_minmax_decimator_core #(
        .SAMPLE_WIDTH(SW)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_time_first   (s_time_first),
        .s_time_second  (s_time_second),
        .s_sample_a     (s_sample_a),
        .s_sample_b     (s_sample_b),
        .s_end_of_stream(s_end_of_stream),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mid_time     (m_mid_time),
        .m_peak_high    (m_peak_high),
        .m_peak_low     (m_peak_low),
        .m_final_flag   (m_final_flag)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // accumulator back to its empty-block values
    function automatic void clear_accumulator();
        acc_count = '0;
        acc_high  = SAMPLE_MIN;
        acc_low   = SAMPLE_MAX;
        acc_start = '0;
    endfunction

    // fold one bar into the open block; returns 1 when the bar yields a result word
    function automatic logic decimate_bar(input bar_t bar, output peak_t res);
        logic signed [SW-1:0]  sa;
        logic signed [SW-1:0]  sb;
        logic [TIME_WIDTH:0]   span_sum;
        sa  = bar.a;
        sb  = bar.b;
        res = '0;
        // pass-through drops any open block
        if (bars_cfg <= 1) begin
            clear_accumulator();
            res = '{bar.t_first, bar.a, bar.b, bar.eos};
            return 1'b1;
        end
        if (acc_count == 0) acc_start = bar.t_first;
        if (sa > acc_high) acc_high = sa;
        if (sb > acc_high) acc_high = sb;
        if (sa < acc_low) acc_low = sa;
        if (sb < acc_low) acc_low = sb;
        if (acc_count != COUNT_MAX) acc_count = acc_count + 1'b1;
        if (acc_count < bars_cfg && !bar.eos) return 1'b0;
        // midpoint formed at one extra bit so it never wraps
        span_sum = {1'b0, acc_start} + {1'b0, bar.t_second};
        res = '{span_sum[TIME_WIDTH:1], acc_high, acc_low, bar.eos};
        clear_accumulator();
        return 1'b1;
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    // offer one word on the input channel, then predict once it is taken
    task automatic send_bar(input bar_t bar, input logic typed, input peak_t want);
        peak_t res;
        logic  emits;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_time_first    <= bar.t_first;
        s_time_second   <= bar.t_second;
        s_sample_a      <= bar.a;
        s_sample_b      <= bar.b;
        s_end_of_stream <= bar.eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        emits = decimate_bar(bar, res);
        if (typed) expected_peaks.push_back(want);
        else if (emits) expected_peaks.push_back(res);
    endtask

    // input idle, every result in, then room for a bar still in flight
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_peaks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bars_cfg(input logic [COUNT_WIDTH-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        bars_cfg = value;
    endtask

    task automatic note_fault(input string what, input peak_t want);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%s: mid exp %h got %h, high exp %h got %h,",
                     what, want.mid, m_mid_time, want.high, m_peak_high,
                     " low exp %h got %h, final exp %b got %b",
                     want.low, m_peak_low, want.fin, m_final_flag);
    endtask

    // result side: random back-pressure and compare against the oldest expectation
    always @(posedge aclk) begin : check_results
        peak_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            if (m_valid && m_ready) begin
                if (expected_peaks.size() == 0) begin
                    note_fault("unexpected result word", NO_WANT);
                end else begin
                    want = expected_peaks.pop_front();
                    if (m_mid_time !== want.mid || m_peak_high !== want.high ||
                        m_peak_low !== want.low || m_final_flag !== want.fin)
                        note_fault("result mismatch", want);
                end
            end
        end
    end

    // watchdog: too long without a word moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("interval_minmax_decimator_core_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned            sent;
        int unsigned            phase_len;
        logic [COUNT_WIDTH-1:0] cfg_pick;
        logic [TIME_WIDTH-1:0]  clock_us;
        bar_t                   bar;

        // set_cfg, cfg, bar {t_first, t_second, a, b, eos}, typed, want {mid, high, low, fin}
        plan = '{
            // pass-through straight after reset, full-range extremes
            '{1'b0, 16'd0, '{32'h0, 32'hFFFF_FFFF, SAMPLE_MAX, SAMPLE_MIN, 1'b0},
              1'b1, '{32'h0, SAMPLE_MAX, SAMPLE_MIN, 1'b0}},
            '{1'b0, 16'd0, '{32'hFFFF_FFFF, 32'h0, SAMPLE_MIN, SAMPLE_MAX, 1'b1},
              1'b1, '{32'hFFFF_FFFF, SAMPLE_MIN, SAMPLE_MAX, 1'b1}},
            // register 0 also passes through
            '{1'b1, 16'd0, '{32'h1234_5678, 32'h9ABC_DEF0, 16'hFFFF, 16'h0000, 1'b0},
              1'b1, '{32'h1234_5678, 16'hFFFF, 16'h0000, 1'b0}},
            // pairs: midpoint sum must not wrap
            '{1'b1, 16'd2, '{32'hFFFF_FFFF, 32'h0, 16'h0005, 16'hFFFB, 1'b0},
              1'b0, NO_WANT},
            '{1'b0, 16'd0, '{32'h0, 32'hFFFF_FFFF, SAMPLE_MAX, SAMPLE_MIN, 1'b0},
              1'b1, '{32'hFFFF_FFFF, SAMPLE_MAX, SAMPLE_MIN, 1'b0}},
            // end of stream flushes a partial block, and a lone marked bar
            '{1'b1, 16'd3, '{32'd10, 32'd20, 16'h0000, 16'h0000, 1'b0},
              1'b0, NO_WANT},
            '{1'b0, 16'd0, '{32'd25, 32'd31, 16'h0001, 16'hFFFF, 1'b1},
              1'b1, '{32'd20, 16'h0001, 16'hFFFF, 1'b1}},
            '{1'b0, 16'd0, '{32'd100, 32'd201, SAMPLE_MIN, SAMPLE_MIN, 1'b1},
              1'b1, '{32'd150, SAMPLE_MIN, SAMPLE_MIN, 1'b1}},
            '{1'b0, 16'd0, '{32'd0, 32'd0, SAMPLE_MAX, SAMPLE_MAX, 1'b1},
              1'b1, '{32'd0, SAMPLE_MAX, SAMPLE_MAX, 1'b1}},
            // register lowered while a block is open: next bar closes it
            '{1'b1, 16'd5, '{32'd1000, 32'd1010, 16'h0100, 16'hFF00, 1'b0},
              1'b0, NO_WANT},
            '{1'b0, 16'd0, '{32'd1020, 32'd1030, 16'h0200, 16'hFE00, 1'b0},
              1'b0, NO_WANT},
            '{1'b0, 16'd0, '{32'd1040, 32'd1050, 16'h0300, 16'hFD00, 1'b0},
              1'b0, NO_WANT},
            '{1'b1, 16'd2, '{32'd1060, 32'd1070, 16'h0050, 16'h0060, 1'b0},
              1'b0, NO_WANT},
            // pass-through drops an open block, then end of stream closes a new one
            '{1'b1, 16'd4, '{32'd2000, 32'd2001, 16'h1234, 16'h4321, 1'b0},
              1'b0, NO_WANT},
            '{1'b0, 16'd0, '{32'd2002, 32'd2003, 16'h7000, 16'h8001, 1'b0},
              1'b0, NO_WANT},
            '{1'b1, 16'd1, '{32'd2004, 32'd2005, 16'h0042, 16'hFFBE, 1'b0},
              1'b1, '{32'd2004, 16'h0042, 16'hFFBE, 1'b0}},
            '{1'b1, 16'd4, '{32'd3000, 32'd3001, 16'h0007, 16'h0003, 1'b0},
              1'b0, NO_WANT},
            '{1'b0, 16'd0, '{32'd3002, 32'd3003, 16'hFFF0, 16'h0010, 1'b1},
              1'b0, NO_WANT},
            // largest register value, closed by end of stream
            '{1'b1, 16'hFFFF, '{32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 1'b0},
              1'b0, NO_WANT},
            '{1'b0, 16'd0, '{32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 1'b1},
              1'b0, NO_WANT}
        };

        bars_cfg = BARS_RESET;
        clear_accumulator();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (plan[i].set_cfg) write_bars_cfg(plan[i].cfg);
            send_bar(plan[i].bar, plan[i].typed, plan[i].want);
        end

        // random phases, each under a fresh register value
        sent = 0;
        while (sent < RANDOM_BARS) begin
            case ($urandom_range(15))
                0: cfg_pick = 16'd0;
                1: cfg_pick = 16'd1;
                2: cfg_pick = 16'hFFFF;
                3: cfg_pick = COUNT_WIDTH'($urandom_range(100, 3000));
                4: cfg_pick = 16'd2;
                default: cfg_pick = COUNT_WIDTH'($urandom_range(2, 12));
            endcase
            write_bars_cfg(cfg_pick);
            phase_len = $urandom_range(20, 100);
            clock_us  = $urandom;
            for (int k = 0; k < phase_len; k++) begin
                steady = (sent >= STEADY_FROM && sent < STEADY_TO);
                // mostly a running time base, sometimes arbitrary stamps
                if ($urandom_range(9) < 8) begin
                    bar.t_first  = clock_us;
                    clock_us     = clock_us + $urandom_range(1, 40);
                    bar.t_second = clock_us;
                    clock_us     = clock_us + $urandom_range(0, 40);
                end else begin
                    bar.t_first  = $urandom;
                    bar.t_second = $urandom;
                end
                bar.a   = pick_sample();
                bar.b   = pick_sample();
                bar.eos = (k == phase_len - 1) ? 1'($urandom_range(1))
                                               : ($urandom_range(29) == 0);
                send_bar(bar, 1'b0, NO_WANT);
                sent++;
            end
        end
        steady = 1'b0;

        drain_results();
        if (fault_count == 0 && expected_peaks.size() == 0) begin
            $display("interval_minmax_decimator_core_tb OK");
        end else begin
            $display("interval_minmax_decimator_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/imd_pkg.sv
hw/rtl/interval_minmax_decimator_core.sv
sim/interval_minmax_decimator_core_tb.sv
